// ===== rtl/core/pnga_pkg.sv =====
`default_nettype none
package pnga_pkg;

  localparam int MaxStats = 6;
  localparam int HessBase = 1 + MaxStats;
  localparam int AccDepth = 1 + MaxStats + MaxStats * MaxStats;
  localparam int AddrW = 6;
  localparam int IdxW = 3;
  localparam int MulW = 34;
  localparam int EtaW = 34;
  localparam int TaylorTerms = 20;
  localparam int DivBits = 4;
  localparam int DivCycles = 64 / DivBits;
  localparam int DivCntW = 4;

  localparam logic [63:0] Ln2Q56 = 64'h00B17217F7D1CF7A;
  localparam logic [63:0] OneQ60 = 64'h1000000000000000;
  localparam logic signed [EtaW-1:0] EtaHigh = 34'sd35651584;
  localparam logic signed [EtaW-1:0] EtaLow = -34'sd25165824;

  localparam logic [1:0] ActAcc = 2'd0;
  localparam logic [1:0] ActRead = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [1:0] KindNll = 2'd0;
  localparam logic [1:0] KindGrad = 2'd1;
  localparam logic [1:0] KindHess = 2'd2;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
  } acc_req_t;

  function automatic logic signed [MulW-1:0] sx16(input logic [15:0] v);
    sx16 = {{(MulW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pnga_mul.sv =====
`default_nettype none
module pnga_mul (
  input  wire logic                                clk,
  input  wire logic signed [pnga_pkg::MulW-1:0]    a,
  input  wire logic signed [pnga_pkg::MulW-1:0]    b,
  output logic signed      [2*pnga_pkg::MulW-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== rtl/core/pnga_div.sv =====
`default_nettype none
module pnga_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [4:0]  divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] dd, dd_next;
  logic [4:0] rem, rem_next;
  logic [pnga_pkg::DivCntW-1:0] cnt;
  logic busy;

  // restoring division, DivBits quotient bits per cycle
  always_comb begin
    logic [5:0] r6;
    dd_next = dd;
    rem_next = rem;
    for (int b = 0; b < pnga_pkg::DivBits; b++) begin
      r6 = {rem_next, dd_next[63]};
      dd_next = {dd_next[62:0], 1'b0};
      if (r6 >= {1'b0, divisor}) begin
        rem_next = 5'(r6 - {1'b0, divisor});
        dd_next[0] = 1'b1;
      end else begin
        rem_next = r6[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pnga_pkg::DivCntW'(pnga_pkg::DivCycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dd <= dd_next;
      rem <= rem_next;
    end
  end

  assign quotient = dd;

endmodule
`default_nettype wire

// ===== rtl/core/pnga_acc.sv =====
`default_nettype none
module pnga_acc (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pnga_pkg::acc_req_t       req,
  input  wire logic signed [63:0]       wr_data,
  output logic signed [63:0]            rd_data
);

  logic [63:0] mem [pnga_pkg::AccDepth];
  logic [pnga_pkg::AccDepth-1:0] vld;
  logic [63:0] mem_q;
  logic hit;

  // an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.clear) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
      hit <= vld[req.rd_addr];
    end
  end

  assign rd_data = hit ? $signed(mem_q) : 64'sd0;

endmodule
`default_nettype wire

// ===== rtl/core/poisson_nll_grad_hess_accumulator_core.sv =====
`default_nettype none
// channel  | direction | handshake          | payload
// input    | in        | in_valid/in_stall  | action, stat_v0..stat_v5, evt_time, is_active
// output   | out       | out_valid/out_stall| kind, row_index, col_index, value, last
// config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
// An accumulate item stalls the input through the dot product and a range check; then, unless a
// zero time or an out-of-range eta fixes the weight, through the ln2 reduction, the exp series up
// to its twentieth-order term (each term: four passes through the shared 34x34 multiplier, one
// pass through the 4-bit-per-cycle divider) and the scaling by the time; then through one update
// per likelihood, gradient and Hessian entry in use. A readout returns every entry in turn and
// waits on out_stall; a clear does not stall. Sync reset resets control, config and valid bits.
module poisson_nll_grad_hess_accumulator_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic signed [15:0] stat_v0,
  input  wire logic signed [15:0] stat_v1,
  input  wire logic signed [15:0] stat_v2,
  input  wire logic signed [15:0] stat_v3,
  input  wire logic signed [15:0] stat_v4,
  input  wire logic signed [15:0] stat_v5,
  input  wire logic [31:0]        evt_time,
  input  wire logic               is_active,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [2:0]              row_index,
  output logic [2:0]              col_index,
  output logic signed [63:0]      value,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE    = 5'd0;
  localparam logic [SW-1:0] S_ETA_MUL = 5'd1;
  localparam logic [SW-1:0] S_ETA_ADD = 5'd2;
  localparam logic [SW-1:0] S_CHECK   = 5'd3;
  localparam logic [SW-1:0] S_RED     = 5'd4;
  localparam logic [SW-1:0] S_TMUL    = 5'd5;
  localparam logic [SW-1:0] S_TACC    = 5'd6;
  localparam logic [SW-1:0] S_TDIV    = 5'd7;
  localparam logic [SW-1:0] S_TWAIT   = 5'd8;
  localparam logic [SW-1:0] S_FMUL    = 5'd9;
  localparam logic [SW-1:0] S_FACC    = 5'd10;
  localparam logic [SW-1:0] S_RND     = 5'd11;
  localparam logic [SW-1:0] S_SHIFT   = 5'd12;
  localparam logic [SW-1:0] S_U_NEXT  = 5'd13;
  localparam logic [SW-1:0] S_U_M1    = 5'd14;
  localparam logic [SW-1:0] S_U_M2    = 5'd15;
  localparam logic [SW-1:0] S_U_WR    = 5'd16;
  localparam logic [SW-1:0] S_RD      = 5'd17;
  localparam logic [SW-1:0] S_RD_W    = 5'd18;
  localparam logic [SW-1:0] S_RD_H    = 5'd19;

  localparam int IW = pnga_pkg::IdxW;
  localparam int MW = pnga_pkg::MulW;
  localparam int EW = pnga_pkg::EtaW;
  localparam int AW = pnga_pkg::AddrW;

  logic [SW-1:0] state;

  logic [2:0] stats_in_use;
  logic [15:0] coef [pnga_pkg::MaxStats];

  logic [15:0] s [pnga_pkg::MaxStats];
  logic [31:0] t;
  logic active;
  logic [2:0] n;
  logic signed [EW-1:0] eta;
  logic signed [63:0] xr;
  logic signed [6:0] k;
  logic [63:0] term, sum;
  logic [4:0] nterm;
  logic [127:0] pacc;
  logic [1:0] q;
  logic [31:0] w;
  logic [1:0] phase;
  logic [IW-1:0] i, j;
  logic [15:0] si;
  logic signed [63:0] acc_v, d2;
  logic use2;

  logic [AW-1:0] ra;
  logic [1:0] rk;
  logic [IW-1:0] rr, rc;

  logic signed [MW-1:0] ma, mb;
  logic signed [2*MW-1:0] mp;
  logic [IW-1:0] sidx;
  logic [15:0] s_rd;
  logic [63:0] r60;
  logic [6:0] sh;
  logic [127:0] rq;
  logic [6:0] pp_sh;
  logic [AW-1:0] entry_addr;
  logic signed [EW-1:0] rnd_eta;
  logic [2:0] n_in;
  logic div_start, div_done;
  logic [63:0] div_q;
  logic [63:0] mulq60;
  pnga_pkg::acc_req_t req;
  logic signed [63:0] wr_data, rd_data;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_acc = in_valid && !in_stall;

  assign r60 = {xr[59:0], 4'b0};
  assign sh = 7'd60 - k;
  assign rq = pacc >> sh;
  assign mulq60 = pacc[123:60];
  assign rnd_eta = (eta + EW'(8)) >>> 4;
  assign n_in = (stats_in_use > 3'(pnga_pkg::MaxStats)) ? 3'(pnga_pkg::MaxStats)
                                                       : stats_in_use;
  assign s_rd = s[sidx];

  always_comb begin
    sidx = i;
    if (state == S_U_NEXT && phase == pnga_pkg::KindHess) begin
      sidx = j;
    end else if (state == S_U_WR) begin
      if (phase == pnga_pkg::KindHess && i != IW'(pnga_pkg::MaxStats - 1)) begin
        sidx = i + 1'b1;
      end else begin
        sidx = '0;
      end
    end
  end

  always_comb begin
    unique case (phase)
      pnga_pkg::KindNll:  entry_addr = '0;
      pnga_pkg::KindGrad: entry_addr = AW'(i) + 1'b1;
      default: entry_addr = AW'(pnga_pkg::HessBase) + AW'(i) * AW'(pnga_pkg::MaxStats)
                            + AW'(j);
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_ETA_MUL: begin
        ma = pnga_pkg::sx16(s[i]);
        mb = pnga_pkg::sx16(coef[i]);
      end
      S_TMUL: begin
        ma = {2'b0, q[1] ? term[63:32] : term[31:0]};
        mb = {2'b0, q[0] ? r60[63:32] : r60[31:0]};
      end
      S_FMUL: begin
        ma = {2'b0, q[0] ? sum[63:32] : sum[31:0]};
        mb = {2'b0, t};
      end
      S_U_NEXT: begin
        if (phase == pnga_pkg::KindHess) begin
          ma = pnga_pkg::sx16(si);
          mb = pnga_pkg::sx16(s_rd);
        end else begin
          ma = pnga_pkg::sx16(s_rd);
          mb = {2'b0, w};
        end
      end
      S_U_M1: begin
        ma = {{(MW-32){mp[31]}}, mp[31:0]};
        mb = {2'b0, w};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    if (state == S_FACC) begin
      pp_sh = q[0] ? 7'd32 : 7'd0;
    end else begin
      unique case (q)
        2'd0: pp_sh = 7'd0;
        2'd3: pp_sh = 7'd64;
        default: pp_sh = 7'd32;
      endcase
    end
  end

  always_comb begin
    req = '0;
    req.clear = in_acc && action == pnga_pkg::ActClear;
    req.rd_en = (state == S_U_NEXT) || (state == S_RD);
    req.rd_addr = (state == S_RD) ? ra : entry_addr;
    req.wr_en = (state == S_U_WR);
    req.wr_addr = entry_addr;
    wr_data = use2 ? pnga_pkg::sat_add(acc_v, d2) : acc_v;
  end

  assign div_start = (state == S_TDIV);

  pnga_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  pnga_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mulq60), .divisor(nterm),
    .done(div_done), .quotient(div_q)
  );

  pnga_acc u_acc (.clk(clk), .rst(rst), .req(req), .wr_data(wr_data), .rd_data(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_in_use <= 3'(pnga_pkg::MaxStats);
      for (int c = 0; c < pnga_pkg::MaxStats; c++) begin
        coef[c] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == '0) begin
        stats_in_use <= cfg_data[2:0];
      end else if (cfg_index <= 3'(pnga_pkg::MaxStats)) begin
        coef[cfg_index - 1'b1] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (action == pnga_pkg::ActAcc) begin
              state <= S_ETA_MUL;
            end else if (action == pnga_pkg::ActRead) begin
              state <= S_RD;
            end
          end
        end
        S_ETA_MUL: state <= S_ETA_ADD;
        S_ETA_ADD: if (i == IW'(pnga_pkg::MaxStats - 1)) state <= S_CHECK;
                   else state <= S_ETA_MUL;
        S_CHECK: begin
          if (t == '0 || eta <= pnga_pkg::EtaLow || eta >= pnga_pkg::EtaHigh) begin
            state <= S_U_NEXT;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: if (!xr[63] && xr < $signed(pnga_pkg::Ln2Q56)) state <= S_TMUL;
        S_TMUL: state <= S_TACC;
        S_TACC: state <= (q == 2'd3) ? S_TDIV : S_TMUL;
        S_TDIV: state <= S_TWAIT;
        S_TWAIT: if (div_done) state <= (nterm == 5'(pnga_pkg::TaylorTerms)) ? S_FMUL
                                                                            : S_TMUL;
        S_FMUL: state <= S_FACC;
        S_FACC: state <= q[0] ? S_RND : S_FMUL;
        S_RND: state <= S_SHIFT;
        S_SHIFT: state <= S_U_NEXT;
        S_U_NEXT: state <= S_U_M1;
        S_U_M1: state <= (phase == pnga_pkg::KindHess) ? S_U_M2 : S_U_WR;
        S_U_M2: state <= S_U_WR;
        S_U_WR: begin
          priority if (phase == pnga_pkg::KindNll && n == '0) begin
            state <= S_IDLE;
          end else if (phase == pnga_pkg::KindHess && i == 3'(n - 1'b1)
                       && j == 3'(n - 1'b1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_U_NEXT;
          end
        end
        S_RD: state <= S_RD_W;
        S_RD_W: begin
          state <= S_RD_H;
          out_valid <= 1'b1;
        end
        S_RD_H: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= last ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        s[0] <= (n_in > 3'd0) ? stat_v0 : 16'd0;
        s[1] <= (n_in > 3'd1) ? stat_v1 : 16'd0;
        s[2] <= (n_in > 3'd2) ? stat_v2 : 16'd0;
        s[3] <= (n_in > 3'd3) ? stat_v3 : 16'd0;
        s[4] <= (n_in > 3'd4) ? stat_v4 : 16'd0;
        s[5] <= (n_in > 3'd5) ? stat_v5 : 16'd0;
        t <= evt_time;
        active <= is_active;
        n <= n_in;
        eta <= '0;
        i <= '0;
        j <= '0;
        ra <= '0;
        rk <= pnga_pkg::KindNll;
        rr <= '0;
        rc <= '0;
      end
      S_ETA_ADD: begin
        eta <= eta + $signed(mp[EW-1:0]);
        if (i != IW'(pnga_pkg::MaxStats - 1)) i <= i + 1'b1;
      end
      S_CHECK: begin
        phase <= pnga_pkg::KindNll;
        i <= '0;
        j <= '0;
        if (t == '0 || eta <= pnga_pkg::EtaLow) begin
          w <= '0;
        end else if (eta >= pnga_pkg::EtaHigh) begin
          w <= '1;
        end
        xr <= $signed({{(64-EW){eta[EW-1]}}, eta}) <<< 36;
        k <= '0;
      end
      S_RED: begin
        if (xr[63]) begin
          xr <= xr + $signed(pnga_pkg::Ln2Q56);
          k <= k - 1'b1;
        end else if (xr >= $signed(pnga_pkg::Ln2Q56)) begin
          xr <= xr - $signed(pnga_pkg::Ln2Q56);
          k <= k + 1'b1;
        end else begin
          term <= pnga_pkg::OneQ60;
          sum <= pnga_pkg::OneQ60;
          nterm <= 5'd1;
          pacc <= '0;
          q <= '0;
        end
      end
      S_TACC, S_FACC: begin
        pacc <= pacc + (128'(mp[63:0]) << pp_sh);
        q <= q + 1'b1;
      end
      S_TWAIT: begin
        if (div_done) begin
          term <= div_q;
          sum <= sum + div_q;
          nterm <= nterm + 1'b1;
          pacc <= '0;
          q <= '0;
        end
      end
      S_RND: pacc <= pacc + (128'd1 << (sh - 1'b1));
      S_SHIFT: w <= (|rq[127:32]) ? 32'hFFFF_FFFF : rq[31:0];
      S_U_NEXT: begin
        if (phase == pnga_pkg::KindNll) begin
          d2 <= -$signed({{(64-EW){rnd_eta[EW-1]}}, rnd_eta});
        end else begin
          d2 <= -$signed({{32{s_rd[15]}}, s_rd, 16'd0});
        end
        use2 <= active && phase != pnga_pkg::KindHess;
      end
      S_U_M1: begin
        if (phase == pnga_pkg::KindNll) begin
          acc_v <= pnga_pkg::sat_add(rd_data, $signed({32'd0, w}));
        end else begin
          acc_v <= pnga_pkg::sat_add(rd_data, $signed(mp[63:0]));
        end
      end
      S_U_M2: acc_v <= pnga_pkg::sat_add(rd_data, $signed(mp[63:0]));
      S_U_WR: begin
        // advance to the next entry
        unique case (phase)
          pnga_pkg::KindNll: begin
            phase <= pnga_pkg::KindGrad;
            i <= '0;
          end
          pnga_pkg::KindGrad: begin
            if (i == 3'(n - 1'b1)) begin
              phase <= pnga_pkg::KindHess;
              i <= '0;
              j <= '0;
              si <= s_rd;
            end else begin
              i <= i + 1'b1;
            end
          end
          default: begin
            if (j == 3'(n - 1'b1)) begin
              j <= '0;
              if (i != 3'(n - 1'b1)) begin
                i <= i + 1'b1;
                si <= s_rd;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        endcase
      end
      S_RD_W: begin
        value <= rd_data;
        kind <= rk;
        row_index <= rr;
        col_index <= rc;
        last <= (ra == AW'(pnga_pkg::AccDepth - 1));
      end
      S_RD_H: begin
        if (!out_stall) begin
          ra <= ra + 1'b1;
          unique case (rk)
            pnga_pkg::KindNll: begin
              rk <= pnga_pkg::KindGrad;
              rr <= '0;
            end
            pnga_pkg::KindGrad: begin
              if (rr == IW'(pnga_pkg::MaxStats - 1)) begin
                rk <= pnga_pkg::KindHess;
                rr <= '0;
                rc <= '0;
              end else begin
                rr <= rr + 1'b1;
              end
            end
            default: begin
              if (rc == IW'(pnga_pkg::MaxStats - 1)) begin
                rc <= '0;
                rr <= rr + 1'b1;
              end else begin
                rc <= rc + 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
